@@ rtl/adcsa_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, widths and helpers of the ADC scan averager.
// Used by adcsa_div and multichannel_adc_scan_averager.
package adcsa_pkg;

    localparam int CHANNELS     = 4;
    localparam int WINDOW_DEPTH = 16;

    localparam int MASK_W   = 4;
    localparam int LEN_W    = 5;
    localparam int SMP_W    = 18;
    localparam int CH_W     = $clog2(CHANNELS);
    localparam int HEAD_W   = $clog2(WINDOW_DEPTH);
    localparam int CNT_W    = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W    = SMP_W + $clog2(WINDOW_DEPTH);
    localparam int NUM_W    = SUM_W + 2;
    localparam int DVD_W    = NUM_W - 1;
    localparam int DEN_W    = CNT_W + 1;
    localparam int RING_AW  = CH_W + HEAD_W;
    localparam int RING_N   = CHANNELS << HEAD_W;
    localparam int NUM_REGS = 6;
    localparam int ADDR_W   = $clog2(NUM_REGS) + 2;
    localparam int REG_W    = ADDR_W - 2;

    localparam logic [REG_W-1:0] REG_POLL_MASK = REG_W'(0);
    localparam logic [REG_W-1:0] REG_AVG_MASK  = REG_W'(1);
    localparam logic [REG_W-1:0] REG_WIN_LEN0  = REG_W'(2);
    localparam logic [REG_W-1:0] REG_WIN_LEN1  = REG_W'(3);
    localparam logic [REG_W-1:0] REG_WIN_LEN2  = REG_W'(4);
    localparam logic [REG_W-1:0] REG_WIN_LEN3  = REG_W'(5);

    typedef struct packed {
        logic            found;
        logic [CH_W-1:0] ch;
    } t_scan;

    function automatic logic chan_en(input logic [CH_W-1:0] c, input logic [MASK_W-1:0] mask);
        logic en;
        en = 1'b0;
        for (int k = 0; k < MASK_W; k++) begin
            if (k < CHANNELS && int'(c) == k && mask[k]) begin
                en = 1'b1;
            end
        end
        return en;
    endfunction

    // Round-robin search after cur, cur itself last.
    function automatic t_scan next_scan(input logic [CH_W-1:0] cur,
                                        input logic [MASK_W-1:0] mask);
        t_scan           res;
        logic [CH_W-1:0] c;
        res.found = 1'b0;
        res.ch    = cur;
        c         = cur;
        for (int i = 0; i < CHANNELS; i++) begin
            c = (int'(c) == CHANNELS - 1) ? '0 : c + 1'b1;
            if (!res.found && chan_en(c, mask)) begin
                res.found = 1'b1;
                res.ch    = c;
            end
        end
        return res;
    endfunction

    function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        logic [CNT_W-1:0] n;
        if (len == '0) begin
            n = CNT_W'(1);
        end else if (32'(len) > WINDOW_DEPTH) begin
            n = CNT_W'(WINDOW_DEPTH);
        end else begin
            n = CNT_W'(len);
        end
        return n;
    endfunction

endpackage

@@ rtl/adcsa_div.sv @@
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on adcsa_pkg for the dividend and divisor widths.
module adcsa_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [adcsa_pkg::DVD_W-1:0] i_dividend,
    input  logic [adcsa_pkg::DEN_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [adcsa_pkg::DVD_W-1:0] o_quotient
);
    import adcsa_pkg::*;

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DVD_W-1:0]  r_q;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W:0]    shifted;
    logic              fits;

    assign shifted = {r_rem, r_q[DVD_W-1]};
    assign fits    = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(DVD_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DVD_W-2:0], fits};
            r_rem <= fits ? DEN_W'(shifted - {1'b0, r_den}) : shifted[DEN_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

@@ rtl/multichannel_adc_scan_averager.sv @@
`timescale 1ns / 1ps
// Multichannel ADC scan averager: scan sequencer, window rings and running sums.
// Depends on adcsa_pkg and adcsa_div.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------------
//  in      | i_valid / o_stall   | i_read_ok, i_conversion_new, i_sample
//  out     | o_valid / i_stall   | o_channel, o_value_updated, o_value,
//          |                     | o_next_channel, o_switched
//  config  | APB psel / penable  | paddr, pwdata, prdata
//
// Disabled, failed, stale and raw polls go from idle straight to done; averaged
// polls add an optional drop (ring read), a push and the 23-step serial divider.
// One word is in work at a time; o_stall is high from acceptance until the
// result is loaded into the output register, which waits while o_valid is stalled.
// Reset clears masks, window lengths to 1, counts, sums, heads and the scan channel.
module multichannel_adc_scan_averager (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_read_ok,
    input  logic                             i_conversion_new,
    input  logic signed [adcsa_pkg::SMP_W-1:0] i_sample,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [1:0]                       o_channel,
    output logic                             o_value_updated,
    output logic signed [adcsa_pkg::SMP_W-1:0] o_value,
    output logic [1:0]                       o_next_channel,
    output logic                             o_switched,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [adcsa_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import adcsa_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DROP  = 6'b000010,
        S_PUSH  = 6'b000100,
        S_START = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state;

    logic [MASK_W-1:0] r_poll_mask;
    logic [MASK_W-1:0] r_avg_mask;
    logic [LEN_W-1:0]  r_win_len [CHANNELS];

    logic [CH_W-1:0]         r_cur;
    logic [CNT_W-1:0]        r_cnt  [CHANNELS];
    logic signed [SUM_W-1:0] r_sum  [CHANNELS];
    logic [HEAD_W-1:0]       r_head [CHANNELS];

    logic signed [SMP_W-1:0] r_ring [RING_N];
    logic signed [SMP_W-1:0] r_rd;

    logic [CH_W-1:0]         r_ch;
    logic signed [SMP_W-1:0] r_sample;
    logic                    r_upd;
    logic                    r_sw;
    logic signed [SMP_W-1:0] r_value;
    logic                    r_neg;

    logic                    r_ovalid;
    logic [CH_W-1:0]         r_o_ch;
    logic                    r_o_upd;
    logic signed [SMP_W-1:0] r_o_value;
    logic [CH_W-1:0]         r_o_next;
    logic                    r_o_sw;

    logic                    accept;
    logic                    cfg_wr;
    logic [REG_W-1:0]        reg_idx;
    t_scan                   scan;
    logic                    need_drop;
    logic [HEAD_W:0]         wr_sum;
    logic [HEAD_W-1:0]       wr_idx;
    logic [HEAD_W-1:0]       head_inc;
    logic signed [NUM_W-1:0] num;
    logic [DVD_W-1:0]        dividend;
    logic                    div_start;
    logic                    div_done;
    logic [DVD_W-1:0]        quotient;
    logic                    out_free;

    assign accept    = i_valid && (r_state == S_IDLE);
    assign o_stall   = (r_state != S_IDLE);
    assign out_free  = !r_ovalid || !i_stall;
    assign cfg_wr    = psel && penable && pwrite;
    assign reg_idx   = paddr[ADDR_W-1:2];
    assign pready    = 1'b1;
    assign scan      = next_scan(r_cur, r_poll_mask);
    assign need_drop = r_cnt[r_cur] >= eff_len(r_win_len[r_cur]);

    assign wr_sum   = {1'b0, r_head[r_ch]} + (HEAD_W + 1)'(r_cnt[r_ch]);
    assign wr_idx   = (32'(wr_sum) >= WINDOW_DEPTH) ?
                      HEAD_W'(32'(wr_sum) - WINDOW_DEPTH) : wr_sum[HEAD_W-1:0];
    assign head_inc = (32'(r_head[r_ch]) == WINDOW_DEPTH - 1) ? '0 : r_head[r_ch] + 1'b1;

    assign num       = {r_sum[r_ch][SUM_W-1], r_sum[r_ch], 1'b0} + NUM_W'(r_cnt[r_ch]);
    assign dividend  = num[NUM_W-1] ? ~num[DVD_W-1:0] : num[DVD_W-1:0];
    assign div_start = (r_state == S_START);

    adcsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  ({r_cnt[r_ch], 1'b0}),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_mask <= '0;
            r_avg_mask  <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_win_len[c] <= LEN_W'(1);
            end
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_POLL_MASK: r_poll_mask  <= pwdata[MASK_W-1:0];
                REG_AVG_MASK:  r_avg_mask   <= pwdata[MASK_W-1:0];
                REG_WIN_LEN0:  r_win_len[0] <= pwdata[LEN_W-1:0];
                REG_WIN_LEN1:  r_win_len[1] <= pwdata[LEN_W-1:0];
                REG_WIN_LEN2:  r_win_len[2] <= pwdata[LEN_W-1:0];
                REG_WIN_LEN3:  r_win_len[3] <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_POLL_MASK: prdata = 32'(r_poll_mask);
            REG_AVG_MASK:  prdata = 32'(r_avg_mask);
            REG_WIN_LEN0:  prdata = 32'(r_win_len[0]);
            REG_WIN_LEN1:  prdata = 32'(r_win_len[1]);
            REG_WIN_LEN2:  prdata = 32'(r_win_len[2]);
            REG_WIN_LEN3:  prdata = 32'(r_win_len[3]);
            default:       prdata = '0;
        endcase
    end

    // Ring: one read port for the oldest entry, one write port for the push.
    always_ff @(posedge i_clk) begin
        r_rd <= r_ring[{r_cur, r_head[r_cur]}];
        if (r_state == S_PUSH) begin
            r_ring[{r_ch, wr_idx}] <= r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cur   <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_cnt[c]  <= '0;
                r_sum[c]  <= '0;
                r_head[c] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (!chan_en(r_cur, r_poll_mask)) begin
                            r_cur   <= scan.ch;
                            r_state <= S_DONE;
                        end else if (i_read_ok && i_conversion_new) begin
                            if (chan_en(r_cur, r_avg_mask)) begin
                                r_state <= need_drop ? S_DROP : S_PUSH;
                            end else begin
                                r_cur   <= scan.ch;
                                r_state <= S_DONE;
                            end
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DROP: begin
                    r_sum[r_ch]  <= r_sum[r_ch] - SUM_W'(r_rd);
                    r_head[r_ch] <= head_inc;
                    r_cnt[r_ch]  <= r_cnt[r_ch] - 1'b1;
                    r_cur        <= scan.ch;
                    r_state      <= S_PUSH;
                end
                S_PUSH: begin
                    r_cnt[r_ch] <= r_cnt[r_ch] + 1'b1;
                    r_sum[r_ch] <= r_sum[r_ch] + SUM_W'(r_sample);
                    r_state     <= S_START;
                end
                S_START: r_state <= S_DIV;
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ch     <= r_cur;
            r_sample <= i_sample;
            r_upd    <= 1'b0;
            r_sw     <= 1'b0;
            r_value  <= '0;
            if (!chan_en(r_cur, r_poll_mask)) begin
                r_sw <= scan.found;
            end else if (i_read_ok && i_conversion_new) begin
                r_upd <= 1'b1;
                if (!chan_en(r_cur, r_avg_mask)) begin
                    r_value <= i_sample;
                    r_sw    <= scan.found;
                end
            end
        end else if (r_state == S_DROP) begin
            r_sw <= scan.found;
        end else if (r_state == S_START) begin
            r_neg <= num[NUM_W-1];
        end else if (r_state == S_DIV && div_done) begin
            r_value <= r_neg ? ~quotient[SMP_W-1:0] : quotient[SMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_o_ch    <= r_ch;
            r_o_upd   <= r_upd;
            r_o_value <= r_value;
            r_o_next  <= r_cur;
            r_o_sw    <= r_sw;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_channel       = 2'(r_o_ch);
    assign o_value_updated = r_o_upd;
    assign o_value         = r_o_value;
    assign o_next_channel  = 2'(r_o_next);
    assign o_switched      = r_o_sw;

endmodule
